@@ rtl/hash_dictionary_encoder_top_macros.svh @@
// Assertion macros shared by the dictionary encoder RTL.
// Each macro expects clk and rst in scope of the module that uses it.
`ifndef HASH_DICTIONARY_ENCODER_TOP_MACROS_SVH
`define HASH_DICTIONARY_ENCODER_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define HDE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hde_pkg.sv @@
// Shared constants, types and state encoding of the hash dictionary encoder.
// No dependencies; every RTL module refers to it by scoped names.
package hde_pkg;

  localparam int KEY_W           = 64;
  localparam int CFG_W           = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd10;

  localparam int CODE_OUT_W      = 10;
  localparam int COUNT_OUT_W     = 32;
  localparam int DIST_OUT_W      = 11;
  localparam int TDATA_IN_W      = 64;
  localparam int TDATA_OUT_W     = 56;

  localparam int MAX_SLOTS_DEF   = 1024;
  localparam int COUNT_WIDTH_DEF = 32;

  // Finalizer constants of the splitmix64 mixer.
  localparam logic [KEY_W-1:0] HASH_M1 = 64'hbf58476d1ce4e5b9;
  localparam logic [KEY_W-1:0] HASH_M2 = 64'h94d049bb133111eb;
  localparam int HASH_SH1 = 30;
  localparam int HASH_SH2 = 27;
  localparam int HASH_SH3 = 31;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_CHECK,
    ST_COUNT,
    ST_DONE
  } state_t;

  // Enables of the slot memory and the count memory.
  typedef struct packed {
    logic slot_rd;
    logic slot_wr;
    logic cnt_rd;
    logic cnt_wr;
  } mem_ctl_t;

endpackage

@@ rtl/hde_hash.sv @@
// Four-stage pipelined splitmix64 finalizer for 64-bit keys.
// Each 64x64 product keeps its low half, built from three 32x32 partial products.
// Depends on hde_pkg.
module hde_hash (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [hde_pkg::KEY_W-1:0] key,
  output logic                      done,
  output logic [hde_pkg::KEY_W-1:0] hash
);

  localparam int KW = hde_pkg::KEY_W;
  localparam int HW = KW / 2;

  logic [3:0]    vld;
  logic [KW-1:0] mix_a;
  logic [KW-1:0] mix_b;
  logic [KW-1:0] ll1;
  logic [HW-1:0] lh1;
  logic [HW-1:0] hl1;
  logic [KW-1:0] x1;
  logic [KW-1:0] ll2;
  logic [HW-1:0] lh2;
  logic [HW-1:0] hl2;
  logic [KW-1:0] x2;
  logic [KW-1:0] ll1_c;
  logic [HW-1:0] lh1_c;
  logic [HW-1:0] hl1_c;
  logic [KW-1:0] ll2_c;
  logic [HW-1:0] lh2_c;
  logic [HW-1:0] hl2_c;

  always_comb begin
    mix_a = key ^ (key >> hde_pkg::HASH_SH1);
    ll1_c = mix_a[HW-1:0] * hde_pkg::HASH_M1[HW-1:0];
    lh1_c = mix_a[HW-1:0] * hde_pkg::HASH_M1[KW-1:HW];
    hl1_c = mix_a[KW-1:HW] * hde_pkg::HASH_M1[HW-1:0];
    mix_b = x1 ^ (x1 >> hde_pkg::HASH_SH2);
    ll2_c = mix_b[HW-1:0] * hde_pkg::HASH_M2[HW-1:0];
    lh2_c = mix_b[HW-1:0] * hde_pkg::HASH_M2[KW-1:HW];
    hl2_c = mix_b[KW-1:HW] * hde_pkg::HASH_M2[HW-1:0];
    x2    = ll2 + {lh2 + hl2, {HW{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    ll1  <= ll1_c;
    lh1  <= lh1_c;
    hl1  <= hl1_c;
    x1   <= ll1 + {lh1 + hl1, {HW{1'b0}}};
    ll2  <= ll2_c;
    lh2  <= lh2_c;
    hl2  <= hl2_c;
    hash <= x2 ^ (x2 >> hde_pkg::HASH_SH3);
  end

  assign done = vld[3];

endmodule

@@ rtl/hde_store.sv @@
// Slot memory (used mark, key, code) and per-code count memory.
// Single-port synchronous RAMs with registered read data; depends on hde_pkg.
module hde_store #(
  parameter int MAX_SLOTS   = hde_pkg::MAX_SLOTS_DEF,
  parameter int COUNT_WIDTH = hde_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                         clk,
  input  hde_pkg::mem_ctl_t                            ctl,
  input  logic [$clog2(MAX_SLOTS)-1:0]                 slot_addr,
  input  logic [$clog2(MAX_SLOTS)+hde_pkg::KEY_W:0]    slot_wdata,
  output logic [$clog2(MAX_SLOTS)+hde_pkg::KEY_W:0]    slot_rdata,
  input  logic [$clog2(MAX_SLOTS)-1:0]                 cnt_addr,
  input  logic [COUNT_WIDTH-1:0]                       cnt_wdata,
  output logic [COUNT_WIDTH-1:0]                       cnt_rdata
);

  localparam int ADDR_W = $clog2(MAX_SLOTS);
  localparam int SLOT_W = 1 + hde_pkg::KEY_W + ADDR_W;

  logic [SLOT_W-1:0]      slot_mem [MAX_SLOTS];
  logic [COUNT_WIDTH-1:0] cnt_mem  [MAX_SLOTS];

  always_ff @(posedge clk) begin
    if (ctl.slot_wr) begin
      slot_mem[slot_addr] <= slot_wdata;
    end
    if (ctl.slot_rd) begin
      slot_rdata <= slot_mem[slot_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cnt_wr) begin
      cnt_mem[cnt_addr] <= cnt_wdata;
    end
    if (ctl.cnt_rd) begin
      cnt_rdata <= cnt_mem[cnt_addr];
    end
  end

endmodule

@@ rtl/hde_probe.sv @@
// Probe sequencer: clearing pass, linear probing, insert, count update and
// the result register. Drives hde_store; takes the hash from hde_hash. Uses hde_pkg.
`include "hash_dictionary_encoder_top_macros.svh"

module hde_probe #(
  parameter int MAX_SLOTS   = hde_pkg::MAX_SLOTS_DEF,
  parameter int COUNT_WIDTH = hde_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic [hde_pkg::CFG_W-1:0]                 cap_log2,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [hde_pkg::KEY_W-1:0]                 in_key,
  input  logic                                      in_last,
  input  logic                                      hash_done,
  input  logic [hde_pkg::KEY_W-1:0]                 hash,
  output hde_pkg::mem_ctl_t                         ctl,
  output logic [$clog2(MAX_SLOTS)-1:0]              slot_addr,
  output logic [$clog2(MAX_SLOTS)+hde_pkg::KEY_W:0] slot_wdata,
  input  logic [$clog2(MAX_SLOTS)+hde_pkg::KEY_W:0] slot_rdata,
  output logic [$clog2(MAX_SLOTS)-1:0]              cnt_addr,
  output logic [COUNT_WIDTH-1:0]                    cnt_wdata,
  input  logic [COUNT_WIDTH-1:0]                    cnt_rdata,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [hde_pkg::TDATA_OUT_W-1:0]           out_data,
  output logic                                      out_last
);

  localparam int ADDR_W      = $clog2(MAX_SLOTS);
  localparam int DIST_W      = ADDR_W + 1;
  localparam int LOG2_MAX    = $clog2(MAX_SLOTS + 1) - 1;
  localparam int LG_W        = $clog2(LOG2_MAX + 1);
  localparam int KW          = hde_pkg::KEY_W;
  localparam int SLOT_W      = 1 + KW + ADDR_W;
  localparam int CODE_OUT_W  = hde_pkg::CODE_OUT_W;
  localparam int COUNT_OUT_W = hde_pkg::COUNT_OUT_W;
  localparam int DIST_OUT_W  = hde_pkg::DIST_OUT_W;
  localparam int PAD_W       = hde_pkg::TDATA_OUT_W - CODE_OUT_W - COUNT_OUT_W - DIST_OUT_W - 2;

  hde_pkg::state_t state, state_next;

  logic [ADDR_W-1:0]      clr_addr;
  logic [KW-1:0]          key_reg;
  logic                   last_reg;
  logic [ADDR_W-1:0]      probe_addr;
  logic [DIST_W-1:0]      probes;
  logic [DIST_W-1:0]      probes_inc;
  logic [DIST_W-1:0]      distinct;
  logic [ADDR_W-1:0]      code_reg;
  logic                   fresh;
  logic                   ovf;
  logic [COUNT_WIDTH-1:0] cnt_res;
  logic [COUNT_WIDTH-1:0] cnt_new;

  logic [LG_W-1:0]        act_lg;
  logic [ADDR_W-1:0]      mask;
  logic [DIST_W-1:0]      cap;

  logic                   ent_used;
  logic [KW-1:0]          ent_key;
  logic [ADDR_W-1:0]      ent_code;

  logic                   do_start;
  logic                   do_insert;
  logic                   do_hit;
  logic                   do_ovf;
  logic                   do_next;
  logic                   load_out;

  logic [CODE_OUT_W-1:0]  res_code;
  logic                   res_new;
  logic [COUNT_OUT_W-1:0] res_count;
  logic [DIST_OUT_W-1:0]  res_dist;
  logic                   res_ovf;

  // Active capacity: register value clamped to 1 .. LOG2_MAX.
  always_comb begin
    if (cap_log2 == '0) begin
      act_lg = LG_W'(1);
    end else if (cap_log2 > LOG2_MAX) begin
      act_lg = LG_W'(LOG2_MAX);
    end else begin
      act_lg = LG_W'(cap_log2);
    end
    mask = ~({ADDR_W{1'b1}} << act_lg);
    cap  = {{(DIST_W-1){1'b0}}, 1'b1} << act_lg;
  end

  assign ent_used   = slot_rdata[SLOT_W-1];
  assign ent_key    = slot_rdata[SLOT_W-2 -: KW];
  assign ent_code   = slot_rdata[ADDR_W-1:0];
  assign probes_inc = probes + 1'b1;
  assign cnt_new    = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;

  always_comb begin
    state_next = state;
    ctl        = '0;
    slot_addr  = probe_addr;
    slot_wdata = '0;
    cnt_addr   = code_reg;
    cnt_wdata  = cnt_new;
    in_ready   = 1'b0;
    do_start   = 1'b0;
    do_insert  = 1'b0;
    do_hit     = 1'b0;
    do_ovf     = 1'b0;
    do_next    = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      hde_pkg::ST_CLEAR: begin
        ctl.slot_wr = 1'b1;
        ctl.cnt_wr  = 1'b1;
        slot_addr   = clr_addr;
        cnt_addr    = clr_addr;
        cnt_wdata   = '0;
        if (clr_addr == ADDR_W'(MAX_SLOTS - 1)) begin
          state_next = hde_pkg::ST_IDLE;
        end
      end
      hde_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = hde_pkg::ST_HASH;
        end
      end
      hde_pkg::ST_HASH: begin
        if (hash_done) begin
          do_start    = 1'b1;
          ctl.slot_rd = 1'b1;
          slot_addr   = hash[ADDR_W-1:0] & mask;
          state_next  = hde_pkg::ST_CHECK;
        end
      end
      hde_pkg::ST_CHECK: begin
        if (!ent_used) begin
          if (distinct < cap) begin
            do_insert   = 1'b1;
            ctl.slot_wr = 1'b1;
            slot_wdata  = {1'b1, key_reg, distinct[ADDR_W-1:0]};
            ctl.cnt_rd  = 1'b1;
            cnt_addr    = distinct[ADDR_W-1:0];
            state_next  = hde_pkg::ST_COUNT;
          end else begin
            do_ovf     = 1'b1;
            state_next = hde_pkg::ST_DONE;
          end
        end else if (ent_key == key_reg) begin
          do_hit     = 1'b1;
          ctl.cnt_rd = 1'b1;
          cnt_addr   = ent_code;
          state_next = hde_pkg::ST_COUNT;
        end else if (probes_inc == cap) begin
          // Every active slot was visited without a match or a free slot.
          do_ovf     = 1'b1;
          state_next = hde_pkg::ST_DONE;
        end else begin
          do_next     = 1'b1;
          ctl.slot_rd = 1'b1;
          slot_addr   = (probe_addr + 1'b1) & mask;
        end
      end
      hde_pkg::ST_COUNT: begin
        ctl.cnt_wr = 1'b1;
        state_next = hde_pkg::ST_DONE;
      end
      hde_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = hde_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hde_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hde_pkg::ST_CLEAR;
      clr_addr  <= '0;
      distinct  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == hde_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (do_insert) begin
        distinct <= distinct + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item payload and probe bookkeeping.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key_reg  <= in_key;
      last_reg <= in_last;
    end
    if (ctl.slot_rd) begin
      probe_addr <= slot_addr;
    end
    if (do_start) begin
      probes <= '0;
      fresh  <= 1'b0;
      ovf    <= 1'b0;
    end else if (do_next) begin
      probes <= probes_inc;
    end
    if (do_insert) begin
      code_reg <= distinct[ADDR_W-1:0];
      fresh    <= 1'b1;
    end else if (do_hit) begin
      code_reg <= ent_code;
    end
    if (do_ovf) begin
      ovf <= 1'b1;
    end
    if (state == hde_pkg::ST_COUNT) begin
      cnt_res <= cnt_new;
    end
  end

  always_comb begin
    res_ovf   = ovf;
    res_dist  = DIST_OUT_W'(distinct);
    if (ovf) begin
      res_code  = '0;
      res_new   = 1'b0;
      res_count = '0;
    end else begin
      res_code  = CODE_OUT_W'(code_reg);
      res_new   = fresh;
      res_count = COUNT_OUT_W'(cnt_res);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= {{PAD_W{1'b0}}, res_ovf, res_dist, res_count, res_new, res_code};
      out_last <= last_reg;
    end
  end

  `HDE_ASSERT_SAME(a_insert_updates_count,
    ctl.slot_wr && (state == hde_pkg::ST_CHECK), ctl.cnt_rd,
    "insert without count update")
  `HDE_ASSERT_NEXT(a_distinct_moves_on_insert,
    !(ctl.slot_wr && (state == hde_pkg::ST_CHECK)), $stable(distinct),
    "distinct count changed without an insert")
  `HDE_ASSERT_SAME(a_probe_bounded,
    state == hde_pkg::ST_CHECK, probes < cap,
    "probe count reached the active capacity")
  `HDE_ASSERT_SAME(a_distinct_in_range,
    1'b1, distinct <= (DIST_W'(1) << LOG2_MAX),
    "distinct count above the largest capacity")

endmodule

@@ rtl/hash_dictionary_encoder_top.sv @@
// Hash dictionary encoder: splitmix64 hash, linear probing table, dense codes.
// Instantiates hde_hash, hde_store and hde_probe; uses hde_pkg.
//
// Input stream: one 64-bit key per item in s_axis_tdata, s_axis_tlast marks
// the last key of a batch. Output stream: one result per item with code,
// new-key flag, saturating occurrence count, distinct count and overflow;
// s_axis_tlast is echoed on m_axis_tlast.
// cfg_wr_en / cfg_wr_data write capacity_log2 (reset 10), clamped to
// 1 .. log2(MAX_SLOTS); it is to be written only while no item is in flight,
// which the user must ensure since the block does nothing to enforce it.
// An accepted key runs through the four-stage hash pipeline; its home slot is
// then read and probing goes on, one slot RAM read per probe, until the key or
// a free slot is found. The count is updated and the result registered before
// the next key is taken, so the lookups of two items never overlap. A new key
// that reaches a free slot when no code is left, or that probes every active
// slot with no match and no free slot, skips the count update and overflows.
// After reset a clearing pass over all MAX_SLOTS entries empties both memories;
// s_axis_tready stays low during it. The result register lets the next key
// be accepted while a result waits; a stalled receiver holds the result and
// the following item finishes its lookup and then waits in place.
module hash_dictionary_encoder_top #(
  parameter int MAX_SLOTS   = hde_pkg::MAX_SLOTS_DEF,
  parameter int COUNT_WIDTH = hde_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // key[63:0]
  input  logic [hde_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // code[9:0], is_new[10], count[42:11], distinct_count[53:43], overflow[54], zero[55]
  output logic [hde_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast,
  input  logic                            cfg_wr_en,
  input  logic [hde_pkg::CFG_W-1:0]       cfg_wr_data
);

  localparam int ADDR_W = $clog2(MAX_SLOTS);
  localparam int SLOT_W = 1 + hde_pkg::KEY_W + ADDR_W;

  logic [hde_pkg::CFG_W-1:0] cap_log2;
  logic                      hash_done;
  logic [hde_pkg::KEY_W-1:0] hash;
  hde_pkg::mem_ctl_t         ctl;
  logic [ADDR_W-1:0]         slot_addr;
  logic [SLOT_W-1:0]         slot_wdata;
  logic [SLOT_W-1:0]         slot_rdata;
  logic [ADDR_W-1:0]         cnt_addr;
  logic [COUNT_WIDTH-1:0]    cnt_wdata;
  logic [COUNT_WIDTH-1:0]    cnt_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_log2 <= hde_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      cap_log2 <= cfg_wr_data;
    end
  end

  hde_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (s_axis_tvalid && s_axis_tready),
    .key   (s_axis_tdata[hde_pkg::KEY_W-1:0]),
    .done  (hash_done),
    .hash  (hash)
  );

  hde_store #(
    .MAX_SLOTS   (MAX_SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_store (
    .clk        (clk),
    .ctl        (ctl),
    .slot_addr  (slot_addr),
    .slot_wdata (slot_wdata),
    .slot_rdata (slot_rdata),
    .cnt_addr   (cnt_addr),
    .cnt_wdata  (cnt_wdata),
    .cnt_rdata  (cnt_rdata)
  );

  hde_probe #(
    .MAX_SLOTS   (MAX_SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_probe (
    .clk        (clk),
    .rst        (rst),
    .cap_log2   (cap_log2),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_key     (s_axis_tdata[hde_pkg::KEY_W-1:0]),
    .in_last    (s_axis_tlast),
    .hash_done  (hash_done),
    .hash       (hash),
    .ctl        (ctl),
    .slot_addr  (slot_addr),
    .slot_wdata (slot_wdata),
    .slot_rdata (slot_rdata),
    .cnt_addr   (cnt_addr),
    .cnt_wdata  (cnt_wdata),
    .cnt_rdata  (cnt_rdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule
